### sv/sequence_difference_classifier_unit_macros.svh
// ============================================================================
// Sequence difference classifier - assertion macros
// Shared property shorthands; expect i_clk and i_rst_n in the using scope.
// ============================================================================
`ifndef SEQUENCE_DIFFERENCE_CLASSIFIER_UNIT_MACROS_SVH
`define SEQUENCE_DIFFERENCE_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SDC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sdc_pkg.sv
// ============================================================================
// sdc_pkg
// Types and constants shared by the sequence difference classifier.
// ============================================================================
package sdc_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int MAX_RESULTS = 64;
    localparam int SYM_W       = 8;
    localparam int POS_W       = 5;

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [1:0] {
        KIND_REF = 2'd0,
        KIND_QRY = 2'd1,
        KIND_CMP = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        EV_SUB     = 3'd0,
        EV_DEL     = 3'd1,
        EV_INS     = 3'd2,
        EV_CPLX    = 3'd3,
        EV_END_DEL = 3'd4,
        EV_END_INS = 3'd5,
        EV_IDENT   = 3'd6
    } t_event;

    typedef struct packed {
        logic [1:0] kind;
        t_sym       symbol;
    } t_item;

    typedef struct packed {
        t_event event_res;
        t_pos   ref_position;
        t_pos   query_position;
        t_sym   ref_symbol;
        t_sym   query_symbol;
        logic   last;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_STEP,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load_ref;
        logic load_qry;
        logic init;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

endpackage

### sv/sequence_difference_classifier_unit.sv
// ============================================================================
// sequence_difference_classifier_unit
// Compares a loaded reference and query symbol sequence and emits one word
// per difference found, or one identical record when there is none.
// ============================================================================
// Usage:
//   Input channel: drive i_item and raise start; the word is taken at a
//   rising edge with start high and busy low. kind REF or QRY appends the
//   symbol to that store (one word per cycle, busy stays low; appends past
//   DEPTH symbols are dropped). kind CMP starts a comparison; kind 3 is a
//   no-op.
//   Result channel: each record sits on o_result for one cycle with
//   o_strobe high; the receiver cannot stall, so sample every strobe. The
//   final record of a comparison carries last.
//   Walk: each pointer step passes through a store read state (FETCH)
//   and a classify state (STEP), at most ref_len + query_len steps, then
//   a FLUSH state closes out. The record stream runs one record behind the
//   walk, since a record is held until the next one shows whether it is
//   the final one. busy drops in the cycle the last record appears.
//   Capacity: at most 64 records per comparison; the walk ends there.
//   Reset: synchronous, active low; both lengths clear, stores are not
//   cleared and need no sweep.
// ============================================================================
module sequence_difference_classifier_unit #(
    parameter int DEPTH = sdc_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sdc_pkg::t_item    i_item,
    output logic              busy,
    output logic              o_strobe,
    output sdc_pkg::t_result  o_result
);

    `include "sequence_difference_classifier_unit_macros.svh"

    sdc_pkg::t_cmd    cmd;
    sdc_pkg::t_status status;

    // sequence the walk: decode words, step pointers, close out
    sdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_kind   (i_item.kind),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // hold the stores and pointers, classify, buffer one record
    sdc_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_symbol (i_item.symbol),
        .i_cmd    (cmd),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // A compare word must occupy the block on the next cycle.
    `SDC_ASSERT_NXT(a_cmp_busy, start && !busy && (i_item.kind == sdc_pkg::KIND_CMP), busy, "compare word did not raise busy")
    // The final record appears only once the block is free again.
    `SDC_ASSERT_IMP(a_last_idle, o_strobe && o_result.last, !busy, "last record while still busy")
    // Any non-final record belongs to a running comparison.
    `SDC_ASSERT_IMP(a_mid_busy, o_strobe && !o_result.last, busy, "mid record outside a comparison")
    // An identical record is alone, final and carries no symbols.
    `SDC_ASSERT_IMP(a_ident_form, o_strobe && (o_result.event_res == sdc_pkg::EV_IDENT), o_result.last && (o_result.ref_symbol == '0) && (o_result.query_symbol == '0), "malformed identical record")

endmodule

### sv/sdc_ram.sv
// ============================================================================
// sdc_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
module sdc_ram #(
    parameter int WIDTH = sdc_pkg::SYM_W,
    parameter int DEPTH = sdc_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### sv/sdc_ctrl.sv
// ============================================================================
// sdc_ctrl
// Controller: decodes accepted words and sequences the compare walk.
// ============================================================================
module sdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_kind,
    input  sdc_pkg::t_status i_status,
    output sdc_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    sdc_pkg::t_state r_state;
    sdc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            sdc_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (i_kind)
                        sdc_pkg::KIND_REF: o_cmd.load_ref = 1'b1;
                        sdc_pkg::KIND_QRY: o_cmd.load_qry = 1'b1;
                        sdc_pkg::KIND_CMP: begin
                            o_cmd.init = 1'b1;
                            n_state    = sdc_pkg::ST_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            // read data lands during STEP; stop once both pointers are spent or the record limit is reached
            sdc_pkg::ST_FETCH: begin
                n_state = i_status.done ? sdc_pkg::ST_FLUSH : sdc_pkg::ST_STEP;
            end
            sdc_pkg::ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = sdc_pkg::ST_FETCH;
            end
            sdc_pkg::ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = sdc_pkg::ST_IDLE;
            end
            default: n_state = sdc_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != sdc_pkg::ST_IDLE);

endmodule

### sv/sdc_dpath.sv
// ============================================================================
// sdc_dpath
// Datapath: symbol stores, lengths, pointers, classifier and record buffer.
// ============================================================================
module sdc_dpath #(
    parameter int DEPTH = sdc_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdc_pkg::t_sym     i_symbol,
    input  sdc_pkg::t_cmd     i_cmd,
    output sdc_pkg::t_status  o_status,
    output logic              o_strobe,
    output sdc_pkg::t_result  o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = $clog2(sdc_pkg::MAX_RESULTS + 1);

    logic [LW-1:0] r_ref_len;
    logic [LW-1:0] r_qry_len;
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_j;
    logic [CW-1:0] r_cnt;
    logic          r_pend_valid;
    logic          r_out_valid;

    sdc_pkg::t_result r_pend;
    sdc_pkg::t_result r_out;

    logic [LW-1:0] ri1;
    logic [LW-1:0] rj1;
    logic          ref_we;
    logic          qry_we;
    sdc_pkg::t_sym a0, a1, b0, b1;

    logic i_lt_n, j_lt_m, i1_lt_n, j1_lt_m;
    logic inc_i, inc_j, rec_valid;
    sdc_pkg::t_event  rec_ev;
    sdc_pkg::t_result rec;
    sdc_pkg::t_result fin;

    assign ri1    = r_i + 1'b1;
    assign rj1    = r_j + 1'b1;
    assign ref_we = i_cmd.load_ref && (r_ref_len < LW'(DEPTH));
    assign qry_we = i_cmd.load_qry && (r_qry_len < LW'(DEPTH));

    sdc_ram #(
        .WIDTH (sdc_pkg::SYM_W),
        .DEPTH (DEPTH)
    ) u_ref_ram (
        .i_clk     (i_clk),
        .i_we      (ref_we),
        .i_waddr   (r_ref_len[AW-1:0]),
        .i_wdata   (i_symbol),
        .i_raddr_a (r_i[AW-1:0]),
        .i_raddr_b (ri1[AW-1:0]),
        .o_rdata_a (a0),
        .o_rdata_b (a1)
    );

    sdc_ram #(
        .WIDTH (sdc_pkg::SYM_W),
        .DEPTH (DEPTH)
    ) u_qry_ram (
        .i_clk     (i_clk),
        .i_we      (qry_we),
        .i_waddr   (r_qry_len[AW-1:0]),
        .i_wdata   (i_symbol),
        .i_raddr_a (r_j[AW-1:0]),
        .i_raddr_b (rj1[AW-1:0]),
        .o_rdata_a (b0),
        .o_rdata_b (b1)
    );

    assign i_lt_n  = (r_i < r_ref_len);
    assign j_lt_m  = (r_j < r_qry_len);
    assign i1_lt_n = (ri1 < r_ref_len);
    assign j1_lt_m = (rj1 < r_qry_len);

    // classify the current pointer pair with one symbol of lookahead
    always_comb begin
        rec_ev    = sdc_pkg::EV_SUB;
        rec_valid = 1'b0;
        inc_i     = 1'b0;
        inc_j     = 1'b0;
        if (i_lt_n && j_lt_m) begin
            if (a0 == b0) begin
                inc_i = 1'b1;
                inc_j = 1'b1;
            end else if (i1_lt_n && j1_lt_m && (a1 == b1)) begin
                rec_valid = 1'b1;
                inc_i     = 1'b1;
                inc_j     = 1'b1;
            end else if (i1_lt_n && (a1 == b0)) begin
                rec_ev    = sdc_pkg::EV_DEL;
                rec_valid = 1'b1;
                inc_i     = 1'b1;
            end else if (j1_lt_m && (a0 == b1)) begin
                rec_ev    = sdc_pkg::EV_INS;
                rec_valid = 1'b1;
                inc_j     = 1'b1;
            end else begin
                rec_ev    = sdc_pkg::EV_CPLX;
                rec_valid = 1'b1;
                inc_i     = 1'b1;
                inc_j     = 1'b1;
            end
        end else if (i_lt_n) begin
            rec_ev    = sdc_pkg::EV_END_DEL;
            rec_valid = 1'b1;
            inc_i     = 1'b1;
        end else if (j_lt_m) begin
            rec_ev    = sdc_pkg::EV_END_INS;
            rec_valid = 1'b1;
            inc_j     = 1'b1;
        end
    end

    always_comb begin
        rec.event_res      = rec_ev;
        rec.ref_position   = sdc_pkg::t_pos'(r_i);
        rec.query_position = sdc_pkg::t_pos'(r_j);
        rec.ref_symbol     = i_lt_n ? a0 : '0;
        rec.query_symbol   = j_lt_m ? b0 : '0;
        rec.last           = 1'b0;
    end

    // final word: the held record tagged last, or the identical record
    always_comb begin
        if (r_pend_valid) begin
            fin      = r_pend;
            fin.last = 1'b1;
        end else begin
            fin.event_res      = sdc_pkg::EV_IDENT;
            fin.ref_position   = sdc_pkg::t_pos'(r_i);
            fin.query_position = sdc_pkg::t_pos'(r_j);
            fin.ref_symbol     = '0;
            fin.query_symbol   = '0;
            fin.last           = 1'b1;
        end
    end

    assign o_status.done = (!i_lt_n && !j_lt_m)
                         || (r_cnt == CW'(sdc_pkg::MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len    <= '0;
            r_qry_len    <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // release the held record when a new one replaces it, or on close out
            r_out_valid <= (i_cmd.step && rec_valid && r_pend_valid) || i_cmd.flush;
            if (ref_we) begin
                r_ref_len <= r_ref_len + 1'b1;
            end
            if (qry_we) begin
                r_qry_len <= r_qry_len + 1'b1;
            end
            if (i_cmd.init) begin
                r_i          <= '0;
                r_j          <= '0;
                r_cnt        <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.step) begin
                r_i <= r_i + LW'(inc_i);
                r_j <= r_j + LW'(inc_j);
                if (rec_valid) begin
                    r_cnt        <= r_cnt + 1'b1;
                    r_pend_valid <= 1'b1;
                end
            end
            if (i_cmd.flush) begin
                r_ref_len <= '0;
                r_qry_len <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && rec_valid) begin
            r_pend <= rec;
            r_out  <= r_pend;
        end
        if (i_cmd.flush) begin
            r_out <= fin;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

### sim/sdc_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// sdc_checker
// Watches the word and record channels of the sequence difference
// classifier, works out the records of every comparison and checks them.
// ============================================================================
module sdc_checker
    import sdc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_item   i_item,
    input  logic    i_strobe,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_records_due,
    output int      o_records_seen
);

    localparam int REPORT_LIMIT = 40;

    t_sym    ref_mem [DEPTH];
    t_sym    qry_mem [DEPTH];
    int      ref_len;
    int      qry_len;
    t_result walk_records [$];
    t_result records_due [$];
    int      fail_count;
    int      records_seen;

    task automatic add_walk_record(input t_event ev, input int i, input int j,
                                   input int n, input int m);
        t_result rec;
        if (walk_records.size() < MAX_RESULTS) begin
            rec.event_res      = ev;
            rec.ref_position   = t_pos'(i);
            rec.query_position = t_pos'(j);
            rec.ref_symbol     = (i < n && i < DEPTH) ? ref_mem[i] : '0;
            rec.query_symbol   = (j < m && j < DEPTH) ? qry_mem[j] : '0;
            rec.last           = 1'b0;
            walk_records = {walk_records, rec};
        end
    endtask

    // Two-pointer walk with one symbol of lookahead; queue its records.
    task automatic walk_sequences();
        int n;
        int m;
        int i;
        int j;
        walk_records.delete();
        n = ref_len;
        m = qry_len;
        i = 0;
        j = 0;
        while (i < n && j < m) begin
            if (ref_mem[i] == qry_mem[j]) begin
                i++;
                j++;
            end else if (i + 1 < n && j + 1 < m && ref_mem[i+1] == qry_mem[j+1]) begin
                add_walk_record(EV_SUB, i, j, n, m);
                i++;
                j++;
            end else if (i + 1 < n && ref_mem[i+1] == qry_mem[j]) begin
                add_walk_record(EV_DEL, i, j, n, m);
                i++;
            end else if (j + 1 < m && ref_mem[i] == qry_mem[j+1]) begin
                add_walk_record(EV_INS, i, j, n, m);
                j++;
            end else begin
                add_walk_record(EV_CPLX, i, j, n, m);
                i++;
                j++;
            end
        end
        while (i < n) begin
            add_walk_record(EV_END_DEL, i, j, n, m);
            i++;
        end
        while (j < m) begin
            add_walk_record(EV_END_INS, i, j, n, m);
            j++;
        end
        if (walk_records.size() == 0)
            add_walk_record(EV_IDENT, i, j, 0, 0);
        walk_records[walk_records.size()-1].last = 1'b1;
        records_due = {records_due, walk_records};
        ref_len = 0;
        qry_len = 0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: record %0d field %s expected %0d, got %0d",
                         $time, records_seen, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            ref_len = 0;
            qry_len = 0;
            records_due.delete();
        end else begin
            if (i_strobe === 1'b1) begin
                records_seen++;
                if (records_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: record %0d expected none, got %h",
                                 $time, records_seen, i_result);
                end else begin
                    want = records_due.pop_front();
                    check_field("event_res", 8'(want.event_res), 8'(i_result.event_res));
                    check_field("ref_position", 8'(want.ref_position),
                                8'(i_result.ref_position));
                    check_field("query_position", 8'(want.query_position),
                                8'(i_result.query_position));
                    check_field("ref_symbol", want.ref_symbol, i_result.ref_symbol);
                    check_field("query_symbol", want.query_symbol, i_result.query_symbol);
                    check_field("last", 8'(want.last), 8'(i_result.last));
                end
            end
            if (i_start && !i_busy) begin
                case (i_item.kind)
                    KIND_REF: begin
                        if (ref_len < DEPTH) begin
                            ref_mem[ref_len] = i_item.symbol;
                            ref_len++;
                        end
                    end
                    KIND_QRY: begin
                        if (qry_len < DEPTH) begin
                            qry_mem[qry_len] = i_item.symbol;
                            qry_len++;
                        end
                    end
                    KIND_CMP: walk_sequences();
                    default: ;
                endcase
            end
        end
        o_fail_count   <= fail_count;
        o_records_due  <= records_due.size();
        o_records_seen <= records_seen;
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives load and compare words into the sequence difference classifier in
// random bursts; a checker beside the block predicts and checks each record.
// ============================================================================
module testbench;
    import sdc_pkg::*;

    localparam int         WORD_TARGET = 460;
    localparam int         DRAIN_LIMIT = 20000;
    localparam int         TAIL_CYCLES = 8;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    int fail_count;
    int records_due;
    int records_seen;

    // Sender bookkeeping: words left in the current burst, words per kind.
    int   burst_left = 0;
    int   kind_count [4];
    int   words_sent = 0;

    // Symbol source for one reference/query pair.
    t_sym alphabet [4];
    int   alpha_n;
    bit   full_range;

    always #5 i_clk = ~i_clk;

    sequence_difference_classifier_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    sdc_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_strobe       (o_strobe),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_records_due  (records_due),
        .o_records_seen (records_seen)
    );

    // Hand one word to the block. Open a new burst when the old one runs
    // out: either a long stretch with no gap or a short burst after a gap.
    // Hold start high between back-to-back words; never drop and re-raise
    // it in one step.
    task automatic send_word(input logic [1:0] kind, input t_sym symbol);
        int    gap;
        t_item word;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(20, 60);
            end else begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 8);
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        word.kind   = kind;
        word.symbol = symbol;
        start  <= 1'b1;
        i_item <= word;
        // busy read right after the edge is its value before the edge.
        do @(posedge i_clk); while (busy);
        kind_count[kind]++;
        if (kind != KIND_UNUSED)
            words_sent++;
    endtask

    // Drop start and hold off until every record due has come back.
    // The first edge lets the checker's count catch up with the last word.
    task automatic wait_drained();
        start <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (records_due != 0);
    endtask

    task automatic run_case(input t_sym ref_seq[$], input t_sym qry_seq[$]);
        foreach (ref_seq[k])
            send_word(KIND_REF, ref_seq[k]);
        foreach (qry_seq[k])
            send_word(KIND_QRY, qry_seq[k]);
        send_word(KIND_CMP, '0);
    endtask

    // Small alphabets make lookahead matches common; the full range
    // toggles every symbol bit.
    function automatic t_sym draw_symbol();
        if (full_range)
            return t_sym'($urandom);
        return alphabet[$urandom_range(0, alpha_n - 1)];
    endfunction

    // One well-formed pair: a reference, a query made from it by point
    // edits (or drawn fresh), loads interleaved at random, then a compare.
    // A few pairs skip the compare so the next one starts on leftovers.
    task automatic run_random_pair(input bit force_long);
        t_sym ref_seq [$];
        t_sym qry_seq [$];
        int   len;
        int   edit;
        int   ri;
        int   qi;
        for (int k = 0; k < 4; k++)
            alphabet[k] = t_sym'($urandom);
        alpha_n    = $urandom_range(2, 4);
        full_range = ($urandom_range(0, 2) == 0);
        // Long pairs can run past DEPTH so the full-store drop is hit.
        if (force_long || $urandom_range(0, 11) == 0)
            len = $urandom_range(28, 36);
        else
            len = $urandom_range(0, 10);
        repeat (len) ref_seq = {ref_seq, draw_symbol()};
        if ($urandom_range(0, 6) == 0) begin
            len = (len > 20) ? $urandom_range(20, 36) : $urandom_range(0, 10);
            repeat (len) qry_seq = {qry_seq, draw_symbol()};
        end else begin
            foreach (ref_seq[k]) begin
                edit = $urandom_range(0, 99);
                if (edit < 10) begin
                    qry_seq = {qry_seq, draw_symbol()};
                end else if (edit < 18) begin
                    // drop this symbol from the query
                end else if (edit < 26) begin
                    qry_seq = {qry_seq, draw_symbol()};
                    qry_seq = {qry_seq, ref_seq[k]};
                end else begin
                    qry_seq = {qry_seq, ref_seq[k]};
                end
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) qry_seq = {qry_seq, draw_symbol()};
        end
        ri = 0;
        qi = 0;
        while (ri < ref_seq.size() || qi < qry_seq.size()) begin
            if (qi >= qry_seq.size() || (ri < ref_seq.size() && $urandom_range(0, 1) == 0)) begin
                send_word(KIND_REF, ref_seq[ri]);
                ri++;
            end else begin
                send_word(KIND_QRY, qry_seq[qi]);
                qi++;
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_word(KIND_CMP, t_sym'($urandom));
    endtask

    initial begin : stimulus
        t_sym r [$];
        t_sym q [$];
        int   pick;
        int   waited;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: both stores empty, the unused kind, then one case per
        // record type with the symbol extremes in the identical case.
        send_word(KIND_CMP, 8'hFF);
        send_word(KIND_UNUSED, 8'hA5);
        r = '{8'h00, 8'hFF};       q = '{8'h00, 8'hFF};
        run_case(r, q);
        r = '{8'h11, 8'h22, 8'h33}; q = '{8'h11, 8'h99, 8'h33};
        run_case(r, q);
        r = '{8'h55, 8'h66, 8'h77}; q = '{8'h66, 8'h77};
        run_case(r, q);
        r = '{8'h44};              q = '{8'h88, 8'h44};
        run_case(r, q);
        // complex change, then a reference tail
        r = '{8'h01, 8'h02};       q = '{8'h03};
        run_case(r, q);
        r.delete();                q = '{8'h07};
        run_case(r, q);
        wait_drained();

        // Random: mostly well-formed pairs, some noise and lone compares.
        run_random_pair(1'b1);
        while (words_sent < WORD_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                run_random_pair(1'b0);
            end else if (pick < 87) begin
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom_range(0, 3)), t_sym'($urandom));
            end else if (pick < 94) begin
                send_word(KIND_CMP, t_sym'($urandom));
            end else begin
                send_word(KIND_UNUSED, t_sym'($urandom));
            end
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end

        // Drain, then wait TAIL_CYCLES more so any stray record shows.
        start <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (records_due != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (records_due != 0)
            $display("%0t: %0d records never arrived", $time, records_due);
        $display("Run covered %0d reference loads, %0d query loads, %0d compares, %0d no-ops.",
                 kind_count[KIND_REF], kind_count[KIND_QRY], kind_count[KIND_CMP],
                 kind_count[KIND_UNUSED]);
        $display("%0d difference records checked, %0d field mismatches.",
                 records_seen, fail_count);
        if (fail_count == 0 && records_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Timeout, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/sdc_pkg.sv
sv/sdc_ram.sv
sv/sdc_ctrl.sv
sv/sdc_dpath.sv
sv/sequence_difference_classifier_unit.sv
sim/sdc_checker.sv
sim/testbench.sv
